// ===== hw/rtl/lsbse_pkg.sv =====
// Shared types and constants for the LSB steganography extractor.
// No dependencies; every other file of the block imports this package.
package lsbse_pkg;

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES       = 2'd1;

  localparam logic [31:0] MAX_MESSAGE_BYTES_RST = 32'd65535;
  localparam logic [31:0] IMAGE_BYTES_RST       = 32'hFFFF_FFFF;

  typedef logic [1:0] status_t;
  localparam status_t ST_DATA      = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_TOO_LONG  = 2'd2;
  localparam status_t ST_TOO_SMALL = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0] max_message_bytes;
    logic [31:0] image_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] message_byte;
    status_t    status;
    logic       last_of_message;
  } result_t;

endpackage

// ===== hw/rtl/lsbse_if.sv =====
// Valid/ready channel interfaces of the LSB steganography extractor.
// Depends on lsbse_pkg for the configuration index width.
interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       start_of_image;
  modport source (output valid, output pixel_byte, output start_of_image, input ready);
  modport sink   (input valid, input pixel_byte, input start_of_image, output ready);
endinterface

interface lsbse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic [1:0] status;
  logic       last_of_message;
  modport source (output valid, output message_byte, output status,
                  output last_of_message, input ready);
  modport sink   (input valid, input message_byte, input status,
                  input last_of_message, output ready);
endinterface

interface lsbse_cfg_if;
  import lsbse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lsbse_core.sv =====
// Input register and decode state of the LSB steganography extractor.
// Depends on lsbse_pkg and the lsbse_in_if interface.
module lsbse_core #(
  parameter int HEADER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  lsbse_in_if.sink          in_ch,
  input  lsbse_pkg::cfg_t   cfg,
  input  logic              buf_ready,
  output logic              push,
  output lsbse_pkg::result_t push_data
);
  import lsbse_pkg::*;

  localparam int CNT_W  = $clog2(HEADER_BITS + 1);
  localparam int NEED_W = (HEADER_BITS + 4 > 32) ? HEADER_BITS + 4 : 32;
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HEADER_BITS);

  logic                   s1_v_r, s1_v_nxt;
  logic                   s1_bit_r;
  logic                   s1_start_r;
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       hcnt_r, hcnt_nxt;
  logic [HEADER_BITS-1:0] len_r, len_nxt;
  logic [HEADER_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]             bib_r, bib_nxt;
  logic [7:0]             bs_r, bs_nxt;

  phase_t                 cur_phase;
  logic [CNT_W-1:0]       cur_hcnt;
  logic [HEADER_BITS-1:0] cur_len;
  logic [HEADER_BITS-1:0] cur_rem;
  logic [2:0]             cur_bib;
  logic [7:0]             cur_bs;
  logic [HEADER_BITS-1:0] shifted_len;
  logic [CNT_W-1:0]       hcnt_inc;
  logic [7:0]             shifted_bs;
  logic [HEADER_BITS-1:0] rem_dec;
  logic [NEED_W-1:0]      len_ext;
  logic [NEED_W-1:0]      need;
  logic                   too_long;
  logic                   too_small;
  logic                   adv;
  logic                   emit;
  result_t                res;

  assign in_ch.ready = !s1_v_r || buf_ready;
  assign adv         = s1_v_r && buf_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  // A start request restarts decoding before its own bit is taken.
  always_comb begin
    if (s1_start_r) begin
      cur_phase = PH_HEADER;
      cur_hcnt  = '0;
      cur_len   = '0;
      cur_rem   = '0;
      cur_bib   = '0;
      cur_bs    = '0;
    end else begin
      cur_phase = phase_r;
      cur_hcnt  = hcnt_r;
      cur_len   = len_r;
      cur_rem   = rem_r;
      cur_bib   = bib_r;
      cur_bs    = bs_r;
    end
  end

  assign shifted_len = {cur_len[HEADER_BITS-2:0], s1_bit_r};
  assign hcnt_inc    = cur_hcnt + CNT_W'(1);
  assign shifted_bs  = {cur_bs[6:0], s1_bit_r};
  assign rem_dec     = cur_rem - HEADER_BITS'(1);
  assign len_ext     = NEED_W'(shifted_len);
  assign need        = NEED_W'(HEADER_BITS) + (len_ext << 3);
  assign too_long    = len_ext > NEED_W'(cfg.max_message_bytes);
  assign too_small   = need > NEED_W'(cfg.image_bytes);

  always_comb begin
    phase_nxt = cur_phase;
    hcnt_nxt  = cur_hcnt;
    len_nxt   = cur_len;
    rem_nxt   = cur_rem;
    bib_nxt   = cur_bib;
    bs_nxt    = cur_bs;
    emit      = 1'b0;
    res.message_byte    = '0;
    res.status          = ST_DATA;
    res.last_of_message = 1'b0;
    case (cur_phase)
      PH_HEADER: begin
        len_nxt  = shifted_len;
        hcnt_nxt = hcnt_inc;
        if (hcnt_inc == HDR_LAST) begin
          phase_nxt           = PH_IDLE;
          res.last_of_message = 1'b1;
          if (too_long) begin
            emit       = 1'b1;
            res.status = ST_TOO_LONG;
          end else if (too_small) begin
            emit       = 1'b1;
            res.status = ST_TOO_SMALL;
          end else if (shifted_len == '0) begin
            emit       = 1'b1;
            res.status = ST_EMPTY;
          end else begin
            rem_nxt   = shifted_len;
            bib_nxt   = '0;
            bs_nxt    = '0;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        bs_nxt  = shifted_bs;
        bib_nxt = cur_bib + 3'd1;
        if (cur_bib == 3'd7) begin
          bs_nxt              = '0;
          rem_nxt             = rem_dec;
          emit                = 1'b1;
          res.message_byte    = shifted_bs;
          res.last_of_message = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        // Idle: the byte is dropped and nothing changes.
      end
    endcase
  end

  assign push      = adv && emit;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_start_r <= 1'b0;
      phase_r    <= PH_IDLE;
      hcnt_r     <= '0;
      len_r      <= '0;
      rem_r      <= '0;
      bib_r      <= '0;
      bs_r       <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (in_ch.valid && in_ch.ready) begin
        s1_start_r <= in_ch.start_of_image;
      end
      if (adv) begin
        phase_r <= phase_nxt;
        hcnt_r  <= hcnt_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
        bib_r   <= bib_nxt;
        bs_r    <= bs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_bit_r <= in_ch.pixel_byte[0];
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.status != ST_DATA |-> push_data.last_of_message)
    else $error("non-data result without last flag");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.last_of_message |=> phase_r == PH_IDLE)
    else $error("decoder not idle after final result");

endmodule

// ===== hw/rtl/lsbse_out_buf.sv =====
// Two-entry output register with skid stage for the extractor's results.
// Depends on lsbse_pkg and the lsbse_out_if interface.
module lsbse_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lsbse_pkg::result_t push_data,
  output logic               buf_ready,
  lsbse_out_if.source        out_ch
);
  import lsbse_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    sk_v_r, sk_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t sk_d_r, sk_d_nxt;
  logic    pop;

  assign pop       = out_v_r && out_ch.ready;
  assign buf_ready = !sk_v_r;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    if (!out_v_r || pop) begin
      if (sk_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      // Output held by the receiver: park the new result in the skid stage.
      sk_v_nxt = 1'b1;
      sk_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.message_byte    = out_d_r.message_byte;
  assign out_ch.status          = out_d_r.status;
  assign out_ch.last_of_message = out_d_r.last_of_message;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !buf_ready |-> !push)
    else $error("result pushed into a full buffer");

endmodule

// ===== hw/rtl/lsb_stego_extractor.sv =====
// Top level of the LSB steganography extractor: configuration registers,
// decode core and output buffer. Depends on lsbse_pkg, lsbse_if, lsbse_core
// and lsbse_out_buf.
//
// Usage: carrier image bytes enter on in_ch, one per request; set
// start_of_image on the first byte of each image. Bit 0 of the first
// HEADER_BITS bytes gives the message length, most significant bit first.
// Results leave on out_ch: data bytes (status 0), an empty-message marker or
// an error code, with last_of_message on the final result of each image.
// cfg_ch writes max_message_bytes (index 0) and image_bytes (index 1); it is
// always ready. It must be written only while no request is in flight; the
// block itself does not enforce this. Throughput is one byte per cycle while
// the output is not stalled; a result passes through the input register, then
// the output register. When the receiver stalls, one further result is parked
// in a skid stage and then in_ch.ready drops until the output drains.
// Reset (synchronous, rst_n low) returns the decoder to idle, empties the
// buffers and restores the configuration defaults; bytes before the first
// start request are dropped.
module lsb_stego_extractor #(
  parameter int HEADER_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  lsbse_in_if.sink     in_ch,
  lsbse_out_if.source  out_ch,
  lsbse_cfg_if.sink    cfg_ch
);
  import lsbse_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    buf_ready;
  logic    push;
  result_t push_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_MESSAGE_BYTES: cfg_nxt.max_message_bytes = cfg_ch.data;
        CFG_IMAGE_BYTES:       cfg_nxt.image_bytes       = cfg_ch.data;
        default: begin
          // Unknown index: the write is dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_bytes <= MAX_MESSAGE_BYTES_RST;
      cfg_r.image_bytes       <= IMAGE_BYTES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lsbse_core #(
    .HEADER_BITS(HEADER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .buf_ready (buf_ready),
    .push      (push),
    .push_data (push_data)
  );

  lsbse_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .buf_ready (buf_ready),
    .out_ch    (out_ch)
  );

endmodule
